/* rtl/drs_pkg.sv */
package drs_pkg;

  localparam int unsigned QueueDepthDef = 1024;
  localparam int unsigned DueW   = 32;
  localparam int unsigned AmtW   = 18;
  localparam int unsigned EntryW = DueW + AmtW;
  localparam int unsigned DeltaW = 17;
  localparam int unsigned DelayW = 16;
  localparam int unsigned RatioW = 18;
  localparam int unsigned SumW   = 48;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [1:0] REQ_RAISE  = 2'd0;
  localparam logic [1:0] REQ_LOWER  = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_H2L = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_L2H = 1'b1;

  localparam logic [CfgW-1:0] H2lReset = 16'd300;
  localparam logic [CfgW-1:0] L2hReset = 16'd0;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,      // capture request, compute due time, pick queue
    OP_APPLY,      // immediate ratio change
    OP_EMPTYINS,   // insert into empty queue
    OP_FULL,       // drop request, flag full
    OP_SCAN_INIT,  // scan pointer to head
    OP_SCAN_RD,    // read entry at scan pointer
    OP_SCAN_NXT,   // advance scan pointer
    OP_MERGE,      // write merged amount at scan pointer
    OP_SHIFT_INIT, // shift pointer to tail
    OP_SHIFT_RD,   // read entry below shift pointer
    OP_SHIFT_WR,   // move read entry up, step shift pointer down
    OP_INS,        // write new entry at scan pointer, bump tail
    OP_HEAD_RD,    // read head entry of selected queue
    OP_POP,        // evaluate head entry for tick, switch to lower queue
    OP_SUM,        // accumulate ratio, advance cycle
    OP_DONE        // present result
  } drs_op_t;

  typedef struct packed {
    logic       q_empty;
    logic       q_full;
    logic       scan_end;   // scan pointer reached tail
    logic       scan_lt;    // entry due < new due
    logic       scan_eq;    // entry due == new due
    logic       shift_end;  // shift pointer reached insert position
    logic       is_delayed;
    logic       sel_lower;  // queue being worked on
    logic [1:0] req;
  } drs_stat_t;

endpackage

/* rtl/drs_ctrl.sv */
module drs_ctrl
  import drs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  drs_stat_t stat,
  output drs_op_t   cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DEC  = 10'b0000000010,
    S_SCHK = 10'b0000000100,
    S_SCMP = 10'b0000001000,
    S_SHCK = 10'b0000010000,
    S_SHWR = 10'b0000100000,
    S_TRD  = 10'b0001000000,
    S_TPOP = 10'b0010000000,
    S_SUM  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } drs_state_t;

  drs_state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.req)
          REQ_TICK: begin
            state_nxt = S_TRD;
          end
          REQ_RAISE, REQ_LOWER: begin
            if (!stat.is_delayed) begin
              cmd = OP_APPLY;
              state_nxt = S_DONE;
            end else if (stat.q_empty) begin
              cmd = OP_EMPTYINS;
              state_nxt = S_DONE;
            end else if (stat.q_full) begin
              cmd = OP_FULL;
              state_nxt = S_DONE;
            end else begin
              cmd = OP_SCAN_INIT;
              state_nxt = S_SCHK;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // stop at tail, else read entry (registered read)
      S_SCHK: begin
        if (stat.scan_end) begin
          cmd = OP_SHIFT_INIT;
          state_nxt = S_SHCK;
        end else begin
          cmd = OP_SCAN_RD;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.scan_lt) begin
          cmd = OP_SCAN_NXT;
          state_nxt = S_SCHK;
        end else if (stat.scan_eq) begin
          cmd = OP_MERGE;
          state_nxt = S_DONE;
        end else begin
          cmd = OP_SHIFT_INIT;
          state_nxt = S_SHCK;
        end
      end
      // move entries up one slot from tail down to insert position
      S_SHCK: begin
        if (stat.shift_end) begin
          cmd = OP_INS;
          state_nxt = S_DONE;
        end else begin
          cmd = OP_SHIFT_RD;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd = OP_SHIFT_WR;
        state_nxt = S_SHCK;
      end
      // tick: raise queue head, then lower queue head
      S_TRD: begin
        cmd = OP_HEAD_RD;
        state_nxt = S_TPOP;
      end
      S_TPOP: begin
        cmd = OP_POP;
        state_nxt = stat.sel_lower ? S_SUM : S_TRD;
      end
      S_SUM: begin
        cmd = OP_SUM;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd = OP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a start while idle always leaves idle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_DEC))
    else $error("start not taken");
  // every result is followed by idle
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (state_r == S_IDLE))
    else $error("done not followed by idle");
  // the sum step only follows a pop
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> ($past(state_r) == S_TPOP))
    else $error("sum out of order");
  // state register stays one-hot
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

endmodule

/* rtl/drs_dp.sv */
module drs_dp
  import drs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  drs_op_t                  cmd,
  output drs_stat_t                stat,
  input  logic [1:0]               in_req_type,
  input  logic [DeltaW-1:0]        in_delta,
  input  logic [DelayW-1:0]        in_delay,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_idx,
  input  logic [CfgW-1:0]          cfg_wdata,
  output logic                     out_valid,
  output logic signed [RatioW-1:0] out_ratio,
  output logic signed [SumW-1:0]   out_ratio_sum,
  output logic [1:0]               out_status,
  output logic [DueW-1:0]          out_now_cycle
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(QUEUE_DEPTH - 1);
  localparam logic signed [RatioW-1:0] RatioMax = {1'b0, {(RatioW-1){1'b1}}};
  localparam logic signed [RatioW-1:0] RatioMin = {1'b1, {(RatioW-1){1'b0}}};

  function automatic logic [PtrW-1:0] nxt_idx(input logic [PtrW-1:0] i);
    nxt_idx = (i == LastIdx) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [PtrW-1:0] prv_idx(input logic [PtrW-1:0] i);
    prv_idx = (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  // queue storage, one memory per queue
  logic [EntryW-1:0] rq_mem [QUEUE_DEPTH];
  logic [EntryW-1:0] lq_mem [QUEUE_DEPTH];
  logic [EntryW-1:0] rq_rd_r, lq_rd_r;

  logic [PtrW-1:0] head_r [2];
  logic [PtrW-1:0] tail_r [2];
  logic [1:0]      empty_r;
  logic [CfgW-1:0] h2l_r, l2h_r;

  logic [1:0]        req_r;
  logic [AmtW-1:0]   amt_r;
  logic [DueW-1:0]   due_r;
  logic              dly_r;
  logic              q_r;     // 0 raise queue, 1 lower queue
  logic [PtrW-1:0]   ptr_r;   // scan / insert position
  logic [PtrW-1:0]   sptr_r;  // shift destination
  logic [DueW-1:0]   cyc_r;
  logic signed [RatioW-1:0] ratio_r;
  logic signed [SumW-1:0]   sum_r;
  logic [1:0]        st_r;

  logic [EntryW-1:0] rd;
  logic [DueW-1:0]   rd_due;
  logic [AmtW-1:0]   rd_amt;
  logic [AmtW:0]     msum;
  logic              en_q;
  logic              pop_hit;
  logic              we;
  logic [PtrW-1:0]   wa;
  logic [EntryW-1:0] wd;
  logic [PtrW-1:0]   ra;
  logic              re;
  logic signed [RatioW+1:0] radd;
  logic signed [RatioW+1:0] rdelta;
  logic signed [RatioW-1:0] rsat;
  logic signed [SumW:0]     sadd;

  assign rd      = q_r ? lq_rd_r : rq_rd_r;
  assign rd_due  = rd[EntryW-1:AmtW];
  assign rd_amt  = rd[AmtW-1:0];
  assign msum    = {1'b0, rd_amt} + {1'b0, amt_r};
  assign en_q    = q_r ? (l2h_r != '0) : (h2l_r != '0);
  assign pop_hit = en_q && !empty_r[q_r] && (rd_due <= cyc_r);

  // status to controller
  always_comb begin
    stat.q_empty    = empty_r[q_r];
    stat.q_full     = (head_r[q_r] == tail_r[q_r]) && !empty_r[q_r];
    stat.scan_end   = (ptr_r == tail_r[q_r]);
    stat.scan_lt    = (rd_due < due_r);
    stat.scan_eq    = (rd_due == due_r);
    stat.shift_end  = (sptr_r == ptr_r);
    stat.is_delayed = dly_r;
    stat.sel_lower  = q_r;
    stat.req        = req_r;
  end

  // ratio change: delta from immediate request or popped amount
  always_comb begin
    rdelta = '0;
    if (cmd == OP_APPLY)
      rdelta = q_r ? -$signed({2'b00, amt_r}) : $signed({2'b00, amt_r});
    else if (cmd == OP_POP && pop_hit && rd_due == cyc_r)
      rdelta = q_r ? -$signed({2'b00, rd_amt}) : $signed({2'b00, rd_amt});
    radd = $signed({ratio_r[RatioW-1], ratio_r[RatioW-1], ratio_r}) + rdelta;
    if (radd[RatioW+1:RatioW-1] != 3'b000 && radd[RatioW+1:RatioW-1] != 3'b111)
      rsat = radd[RatioW+1] ? RatioMin : RatioMax;
    else
      rsat = radd[RatioW-1:0];
    sadd = $signed({sum_r[SumW-1], sum_r}) +
           $signed({{(SumW-RatioW+1){ratio_r[RatioW-1]}}, ratio_r});
  end

  // memory address and write data
  always_comb begin
    we = 1'b0;
    wa = ptr_r;
    wd = {due_r, amt_r};
    ra = ptr_r;
    re = 1'b0;
    case (cmd)
      OP_EMPTYINS: begin
        we = 1'b1;
        wa = head_r[q_r];
      end
      OP_SCAN_RD: re = 1'b1;
      OP_MERGE: begin
        we = 1'b1;
        wd = {due_r, msum[AmtW] ? {AmtW{1'b1}} : msum[AmtW-1:0]};
      end
      OP_SHIFT_RD: begin
        re = 1'b1;
        ra = prv_idx(sptr_r);
      end
      OP_SHIFT_WR: begin
        we = 1'b1;
        wa = sptr_r;
        wd = rd;
      end
      OP_INS: we = 1'b1;
      OP_HEAD_RD: begin
        re = 1'b1;
        ra = head_r[q_r];
      end
      default: ;
    endcase
  end

  // queue memories
  always_ff @(posedge clk) begin
    if (we && !q_r) rq_mem[wa] <= wd;
    if (we && q_r)  lq_mem[wa] <= wd;
    if (re && !q_r) rq_rd_r <= rq_mem[ra];
    if (re && q_r)  lq_rd_r <= lq_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r[0] <= '0; head_r[1] <= '0;
      tail_r[0] <= '0; tail_r[1] <= '0;
      empty_r   <= 2'b11;
      cyc_r     <= '0;
      ratio_r   <= '0;
      sum_r     <= '0;
      h2l_r     <= H2lReset;
      l2h_r     <= L2hReset;
      out_valid <= 1'b0;
      req_r     <= REQ_RAISE;
      amt_r     <= '0;
      due_r     <= '0;
      dly_r     <= 1'b0;
      q_r       <= 1'b0;
      ptr_r     <= '0;
      sptr_r    <= '0;
      st_r      <= ST_OK;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we && cfg_idx == CFG_H2L) h2l_r <= cfg_wdata;
      if (cfg_we && cfg_idx == CFG_L2H) l2h_r <= cfg_wdata;
      case (cmd)
        OP_LATCH: begin
          req_r <= in_req_type;
          amt_r <= {1'b0, in_delta};
          due_r <= cyc_r + {{(DueW-DelayW){1'b0}}, in_delay};
          dly_r <= (in_delay != '0);
          q_r   <= (in_req_type == REQ_LOWER);
          st_r  <= ST_OK;
        end
        OP_APPLY: ratio_r <= rsat;
        OP_EMPTYINS: begin
          tail_r[q_r]  <= nxt_idx(head_r[q_r]);
          empty_r[q_r] <= 1'b0;
        end
        OP_FULL: st_r <= ST_FULL;
        OP_SCAN_INIT: ptr_r <= head_r[q_r];
        OP_SCAN_NXT: ptr_r <= nxt_idx(ptr_r);
        OP_SHIFT_INIT: sptr_r <= tail_r[q_r];
        OP_SHIFT_WR: sptr_r <= prv_idx(sptr_r);
        OP_INS: tail_r[q_r] <= nxt_idx(tail_r[q_r]);
        OP_POP: begin
          if (pop_hit) begin
            if (rd_due < cyc_r) st_r <= ST_STALE;
            else ratio_r <= rsat;
            head_r[q_r] <= nxt_idx(head_r[q_r]);
            if (nxt_idx(head_r[q_r]) == tail_r[q_r]) empty_r[q_r] <= 1'b1;
          end
          q_r <= 1'b1;
        end
        OP_SUM: begin
          cyc_r <= cyc_r + 1'b1;
          if (sadd[SumW] != sadd[SumW-1])
            sum_r <= sadd[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
          else
            sum_r <= sadd[SumW-1:0];
        end
        OP_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // result ports straight from the state registers
  always_comb begin
    out_ratio     = ratio_r;
    out_ratio_sum = sum_r;
    out_status    = st_r;
    out_now_cycle = cyc_r;
  end

  // a result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  // an empty raise queue has head at tail
  a_raise_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r[0] |-> (head_r[0] == tail_r[0]))
    else $error("raise queue empty with head off tail");
  // an empty lower queue has head at tail
  a_lower_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r[1] |-> (head_r[1] == tail_r[1]))
    else $error("lower queue empty with head off tail");

endmodule

/* rtl/delayed_ratio_event_scheduler.sv */
// Channel  | Ports                                        | Handshake
// input    | in_req_type, in_delta, in_delay              | start & !busy
// result   | out_ratio, out_ratio_sum, out_status,        | out_valid, one cycle
//          | out_now_cycle                                |
// config   | cfg_we, cfg_idx, cfg_wdata                   | cfg_we
// Immediate, unused, dropped and empty-queue requests go from decode straight
// to the result state; ticks read and pop both queue heads (two head reads).
// A delayed insert walks the queue entry by entry (registered memory read)
// and then shifts the tail region up entry by entry. No clearing pass after
// reset.
// Results cannot be stalled; busy drops as the result cycle begins.
module delayed_ratio_event_scheduler
  import drs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [DeltaW-1:0]        in_delta,
  input  logic [DelayW-1:0]        in_delay,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_idx,
  input  logic [CfgW-1:0]          cfg_wdata,
  output logic                     out_valid,
  output logic signed [RatioW-1:0] out_ratio,
  output logic signed [SumW-1:0]   out_ratio_sum,
  output logic [1:0]               out_status,
  output logic [DueW-1:0]          out_now_cycle
);

  drs_op_t   cmd;
  drs_stat_t stat;

  drs_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .stat, .cmd
  );

  drs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_req_type, .in_delta, .in_delay,
    .cfg_we, .cfg_idx, .cfg_wdata,
    .out_valid, .out_ratio, .out_ratio_sum, .out_status, .out_now_cycle
  );

endmodule
